FILE: design/krg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the KISS random generator.
// Used by krg_div and kiss_random_generator_unit; no dependencies.
package krg_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 8;

  typedef logic [WordW-1:0]   word_t;
  typedef logic [2*WordW-1:0] dword_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Register indexes of the configuration port
  localparam cfg_idx_t CfgSeedLcg = cfg_idx_t'(0);
  localparam cfg_idx_t CfgSeedXs  = cfg_idx_t'(1);
  localparam cfg_idx_t CfgSeedMwc = cfg_idx_t'(2);
  localparam cfg_idx_t CfgSeedCar = cfg_idx_t'(3);

  // Seed reset values
  localparam word_t RstSeedLcg = word_t'(123456789);
  localparam word_t RstSeedXs  = word_t'(987654321);
  localparam word_t RstSeedMwc = word_t'(43219876);
  localparam word_t RstSeedCar = word_t'(6543217);

  // Generator constants
  localparam word_t LcgMul = word_t'(69069);
  localparam word_t LcgAdd = word_t'(12345);
  localparam word_t MwcMul = word_t'(698769069);
  localparam int unsigned XsA = 13;
  localparam int unsigned XsB = 17;
  localparam int unsigned XsC = 5;

  // Remainder unit: one quotient bit per cycle
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t rem;
  } div_rsp_t;

endpackage

FILE: design/krg_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring remainder unit, one bit per cycle.
// Depends on krg_pkg for word and request/response types.
module krg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  krg_pkg::div_req_t req_i,
  output krg_pkg::div_rsp_t rsp_o
);

  localparam logic [krg_pkg::DivCntW-1:0] LastStep =
    krg_pkg::DivCntW'(krg_pkg::DivSteps - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [krg_pkg::DivCntW-1:0] cnt_q, cnt_d;
  krg_pkg::word_t              rem_q, rem_d;
  krg_pkg::word_t              dvd_q, dvd_d;
  krg_pkg::word_t              dvs_q, dvs_d;

  logic [krg_pkg::WordW:0] shifted;
  logic [krg_pkg::WordW:0] trial;
  logic                    fits;

  always_comb begin
    shifted = {rem_q, dvd_q[krg_pkg::WordW-1]};
    trial   = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract where it fits
      rem_d = fits ? trial[krg_pkg::WordW-1:0] : shifted[krg_pkg::WordW-1:0];
      dvd_d = {dvd_q[krg_pkg::WordW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: design/kiss_random_generator_unit.sv
`timescale 1ns / 1ps
// KISS random generator top level: state words, sequencer, shared multiplier.
// Depends on krg_pkg and krg_div.

// 32-bit KISS generator (congruential + 13/17/5 xorshift + multiply-with-carry).
// One request is handled at a time: a raw draw passes the states StLcg,
// StMwc, StSum, StRaw and StMap to StOut, a range-mapped draw also StDiv,
// where it waits for the one-bit-per-cycle remainder unit. Both
// multiplications share a single 32x32 multiplier on successive cycles.
// in_stall_o is high while a request is in flight; a finished word waits in
// the output register, so the next request can be taken while it is still
// stalled. Seed writes go through the cfg port (index 0..3, higher indexes
// ignored) and also load the state; write them only while the block is idle.
module kiss_random_generator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                use_range_i,
  input  krg_pkg::word_t      range_low_i,
  input  krg_pkg::word_t      range_high_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output krg_pkg::word_t      value_o,
  output logic                seed_invalid_o,
  // seed write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  krg_pkg::cfg_idx_t   cfg_index_i,
  input  krg_pkg::word_t      cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLcg  = 3'd1;
  localparam logic [2:0] StMwc  = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StRaw  = 3'd4;
  localparam logic [2:0] StMap  = 3'd5;
  localparam logic [2:0] StDiv  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0] state_q, state_d;

  krg_pkg::word_t  lcg_q, lcg_d;
  krg_pkg::word_t  xs_q, xs_d;
  krg_pkg::word_t  mwc_q, mwc_d;
  krg_pkg::word_t  car_q, car_d;
  logic [3:0]      seed_zero_q, seed_zero_d;

  logic            use_range_q, use_range_d;
  krg_pkg::word_t  low_q, low_d;
  krg_pkg::word_t  high_q, high_d;
  krg_pkg::dword_t prod_q, prod_d;
  krg_pkg::word_t  raw_q, raw_d;
  krg_pkg::word_t  span_q, span_d;
  krg_pkg::word_t  res_q, res_d;

  logic            out_valid_q, out_valid_d;
  krg_pkg::word_t  value_q, value_d;
  logic            seed_inv_q, seed_inv_d;

  logic            in_acc;
  logic            cfg_acc;
  logic            out_free;
  krg_pkg::word_t  mul_a;
  krg_pkg::word_t  mul_b;
  krg_pkg::word_t  xs1, xs2, xs3;
  krg_pkg::dword_t mwc_sum;

  krg_pkg::div_req_t div_req;
  krg_pkg::div_rsp_t div_rsp;

  krg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // one multiplier, congruential word first, then multiply-with-carry word
  always_comb begin
    mul_a  = (state_q == StLcg) ? lcg_q : mwc_q;
    mul_b  = (state_q == StLcg) ? krg_pkg::LcgMul : krg_pkg::MwcMul;
    prod_d = krg_pkg::dword_t'(mul_a) * krg_pkg::dword_t'(mul_b);
  end

  always_comb begin
    xs1     = xs_q ^ (xs_q << krg_pkg::XsA);
    xs2     = xs1 ^ (xs1 >> krg_pkg::XsB);
    xs3     = xs2 ^ (xs2 << krg_pkg::XsC);
    mwc_sum = prod_q + krg_pkg::dword_t'(car_q);
  end

  always_comb begin
    state_d     = state_q;
    lcg_d       = lcg_q;
    xs_d        = xs_q;
    mwc_d       = mwc_q;
    car_d       = car_q;
    seed_zero_d = seed_zero_q;
    use_range_d = use_range_q;
    low_d       = low_q;
    high_d      = high_q;
    raw_d       = raw_q;
    span_d      = span_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    seed_inv_d  = seed_inv_q;
    div_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_acc) begin
      unique case (cfg_index_i)
        krg_pkg::CfgSeedLcg: begin
          lcg_d          = cfg_data_i;
          seed_zero_d[0] = (cfg_data_i == '0);
        end
        krg_pkg::CfgSeedXs: begin
          xs_d           = cfg_data_i;
          seed_zero_d[1] = (cfg_data_i == '0);
        end
        krg_pkg::CfgSeedMwc: begin
          mwc_d          = cfg_data_i;
          seed_zero_d[2] = (cfg_data_i == '0);
        end
        krg_pkg::CfgSeedCar: begin
          car_d          = cfg_data_i;
          seed_zero_d[3] = (cfg_data_i == '0);
        end
        default: begin
        end
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          use_range_d = use_range_i;
          low_d       = range_low_i;
          high_d      = range_high_i;
          state_d     = StLcg;
        end
      end
      StLcg: begin
        state_d = StMwc;
      end
      StMwc: begin
        lcg_d   = prod_q[krg_pkg::WordW-1:0] + krg_pkg::LcgAdd;
        xs_d    = xs3;
        state_d = StSum;
      end
      StSum: begin
        mwc_d   = mwc_sum[krg_pkg::WordW-1:0];
        car_d   = mwc_sum[2*krg_pkg::WordW-1:krg_pkg::WordW];
        state_d = StRaw;
      end
      StRaw: begin
        raw_d   = lcg_q + xs_q + mwc_q;
        span_d  = high_q - low_q + 1'b1;
        state_d = StMap;
      end
      StMap: begin
        // a span that wraps to zero covers every value: keep the raw draw
        if (use_range_q && (span_q != '0)) begin
          div_req.start    = 1'b1;
          div_req.dividend = raw_q;
          div_req.divisor  = span_q;
          state_d          = StDiv;
        end else begin
          res_d   = raw_q;
          state_d = StOut;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.rem + low_q;
          state_d = StOut;
        end
      end
      StOut: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = res_q;
          seed_inv_d  = &seed_zero_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lcg_q       <= krg_pkg::RstSeedLcg;
      xs_q        <= krg_pkg::RstSeedXs;
      mwc_q       <= krg_pkg::RstSeedMwc;
      car_q       <= krg_pkg::RstSeedCar;
      seed_zero_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcg_q       <= lcg_d;
      xs_q        <= xs_d;
      mwc_q       <= mwc_d;
      car_q       <= car_d;
      seed_zero_q <= seed_zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    use_range_q <= use_range_d;
    low_q       <= low_d;
    high_q      <= high_d;
    prod_q      <= prod_d;
    raw_q       <= raw_d;
    span_q      <= span_d;
    res_q       <= res_d;
    value_q     <= value_d;
    seed_inv_q  <= seed_inv_d;
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign seed_invalid_o = seed_inv_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StLcg))
    else $error("sequencer did not start after an accepted request");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StDiv))
    else $error("remainder finished outside the divide wait");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == StOut))
    else $error("result word appeared without passing the output step");

  a_out_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StOut) && out_valid_o && out_stall_i) |=> (state_q == StOut))
    else $error("pending result word overwritten");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of kiss_random_generator_unit: seed writes, raw and
// range-mapped draws, each result checked against an in-bench generator model.
// Depends on krg_pkg and the design sources.
module testbench;

  typedef struct packed {
    logic           use_range;
    krg_pkg::word_t low;
    krg_pkg::word_t high;
  } draw_req_t;

  typedef struct packed {
    krg_pkg::word_t value;
    logic           seed_invalid;
  } draw_t;

  localparam krg_pkg::word_t CongMul  = 32'd69069;
  localparam krg_pkg::word_t CongAdd  = 32'd12345;
  localparam logic [63:0]    CarryMul = 64'd698769069;
  localparam krg_pkg::word_t AllOnes  = 32'hFFFF_FFFF;

  // indexes past the last seed register; writes to them must be dropped
  localparam krg_pkg::cfg_idx_t CfgIdxUnused = krg_pkg::cfg_idx_t'(4);
  localparam krg_pkg::cfg_idx_t CfgIdxTop    = krg_pkg::cfg_idx_t'(255);

  localparam int unsigned SettleCycles    = 48;
  localparam int unsigned ShownMismatches = 10;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              req_valid      = 1'b0;
  logic              req_stall;
  logic              req_use_range  = 1'b0;
  krg_pkg::word_t    req_low        = '0;
  krg_pkg::word_t    req_high       = '0;
  logic              res_valid;
  logic              res_stall      = 1'b0;
  krg_pkg::word_t    res_value;
  logic              res_seed_invalid;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  krg_pkg::cfg_idx_t cfg_index      = '0;
  krg_pkg::word_t    cfg_data       = '0;

  // model copy of seeds and generator state
  krg_pkg::word_t seed_lcg   = krg_pkg::RstSeedLcg;
  krg_pkg::word_t seed_xs    = krg_pkg::RstSeedXs;
  krg_pkg::word_t seed_mwc   = krg_pkg::RstSeedMwc;
  krg_pkg::word_t seed_carry = krg_pkg::RstSeedCar;
  krg_pkg::word_t lcg_st     = krg_pkg::RstSeedLcg;
  krg_pkg::word_t xs_st      = krg_pkg::RstSeedXs;
  krg_pkg::word_t mwc_st     = krg_pkg::RstSeedMwc;
  krg_pkg::word_t carry_st   = krg_pkg::RstSeedCar;

  draw_t       expected_draws[$];
  draw_t       oldest_draw;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  kiss_random_generator_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (req_valid),
    .in_stall_o     (req_stall),
    .use_range_i    (req_use_range),
    .range_low_i    (req_low),
    .range_high_i   (req_high),
    .out_valid_o    (res_valid),
    .out_stall_i    (res_stall),
    .value_o        (res_value),
    .seed_invalid_o (res_seed_invalid),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance all three generators and form the expected word.
  function automatic draw_t kiss_draw(input logic use_range, input krg_pkg::word_t lo,
                                      input krg_pkg::word_t hi);
    logic [63:0]    prod;
    krg_pkg::word_t xs;
    krg_pkg::word_t raw;
    krg_pkg::word_t span;
    draw_t          d;
    lcg_st = lcg_st * CongMul + CongAdd;
    xs = xs_st;
    xs = xs ^ (xs << 13);
    xs = xs ^ (xs >> 17);
    xs = xs ^ (xs << 5);
    xs_st = xs;
    prod = CarryMul * {32'd0, mwc_st} + {32'd0, carry_st};
    carry_st = prod[63:32];
    mwc_st = prod[31:0];
    raw = lcg_st + xs_st + mwc_st;
    span = hi - lo + 32'd1;
    // a span that wraps to zero covers every value: keep the raw draw
    d.value = (use_range && span != '0) ? krg_pkg::word_t'(raw % span + lo) : raw;
    d.seed_invalid = ((seed_lcg | seed_xs | seed_mwc | seed_carry) == '0);
    return d;
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t r;
    int unsigned kind;
    kind = $urandom_range(9);
    r.use_range = (kind >= 4);
    r.low = $urandom;
    r.high = $urandom;
    case (kind)
      4, 5: r.high = r.low + $urandom_range(255);
      7: r.high = r.low - 32'd1;
      8: begin
        r.low = $urandom_range(1000);
        r.high = r.low + $urandom_range(1 << 20);
      end
      9: begin
        r.low = '0;
        r.high = AllOnes >> $urandom_range(31);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Present one request word and hold it until the block takes it.
  task automatic send_request(input logic use_range, input krg_pkg::word_t lo,
                              input krg_pkg::word_t hi);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_use_range <= use_range;
    req_low <= lo;
    req_high <= hi;
    do @(posedge clk); while (req_stall);
    expected_draws.push_back(kiss_draw(use_range, lo, hi));
  endtask

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_seed(input krg_pkg::cfg_idx_t idx, input krg_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      krg_pkg::CfgSeedLcg: begin seed_lcg = data;   lcg_st = data;   end
      krg_pkg::CfgSeedXs:  begin seed_xs = data;    xs_st = data;    end
      krg_pkg::CfgSeedMwc: begin seed_mwc = data;   mwc_st = data;   end
      krg_pkg::CfgSeedCar: begin seed_carry = data; carry_st = data; end
      default: ;
    endcase
  endtask

  task automatic program_seeds(input krg_pkg::word_t lcg, input krg_pkg::word_t xs,
                               input krg_pkg::word_t mwc, input krg_pkg::word_t car);
    write_seed(krg_pkg::CfgSeedLcg, lcg);
    write_seed(krg_pkg::CfgSeedXs, xs);
    write_seed(krg_pkg::CfgSeedMwc, mwc);
    write_seed(krg_pkg::CfgSeedCar, car);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every expected word; optionally let the pipe settle.
  task automatic drain_results(input bit settle);
    req_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    if (settle) repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_range_edges();
    send_request(1'b0, '0, '0);
    send_request(1'b0, AllOnes, AllOnes);
    send_request(1'b1, '0, AllOnes);
    send_request(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(1'b1, 32'd1, '0);
    send_request(1'b1, 32'd1000, 32'd10);
    send_request(1'b1, AllOnes, AllOnes);
    send_request(1'b1, '0, '0);
    send_request(1'b1, AllOnes, '0);
    send_request(1'b1, '0, 32'hFFFF_FFFE);
    drain_results(1'b1);
  endtask

  task automatic test_seed_registers();
    program_seeds('0, '0, '0, '0);
    send_request(1'b0, '0, '0);
    send_request(1'b1, 32'd3, 32'd17);
    drain_results(1'b1);
    // out-of-range indexes leave the seeds zero
    write_seed(CfgIdxUnused, AllOnes);
    write_seed(CfgIdxTop, 32'h1234_5678);
    cfg_valid <= 1'b0;
    send_request(1'b0, '0, '0);
    drain_results(1'b1);
    write_seed(krg_pkg::CfgSeedCar, 32'd1);
    cfg_valid <= 1'b0;
    send_request(1'b0, '0, '0);
    drain_results(1'b1);
    program_seeds(AllOnes, AllOnes, AllOnes, AllOnes);
    send_request(1'b0, '0, '0);
    send_request(1'b1, 32'h0000_0100, 32'h0001_0000);
    drain_results(1'b1);
    program_seeds(krg_pkg::RstSeedLcg, krg_pkg::RstSeedXs, krg_pkg::RstSeedMwc,
                  krg_pkg::RstSeedCar);
    send_request(1'b1, 32'd7, 32'd7);
    drain_results(1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count, input bit pause_midway);
    draw_req_t r;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    program_seeds($urandom, $urandom, $urandom, $urandom);
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain_results(1'b0);
      r = random_request();
      send_request(r.use_range, r.low, r.high);
    end
    drain_results(1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && res_valid && !res_stall) begin
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownMismatches)
          $display("unexpected result word: value 0x%08h seed_invalid %0b",
                   res_value, res_seed_invalid);
      end else begin
        oldest_draw = expected_draws.pop_front();
        if (res_value !== oldest_draw.value ||
            res_seed_invalid !== oldest_draw.seed_invalid) begin
          mismatches++;
          if (mismatches <= ShownMismatches)
            $display("bad result word: value exp 0x%08h got 0x%08h, %s %0b got %0b",
                     oldest_draw.value, res_value, "seed_invalid exp",
                     oldest_draw.seed_invalid, res_seed_invalid);
        end
      end
    end
    res_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_range_edges();
    test_seed_registers();
    test_random_traffic(0, 0, 282, 1'b0);
    test_random_traffic(62, 0, 282, 1'b1);
    test_random_traffic(0, 62, 282, 1'b0);
    test_random_traffic(36, 36, 282, 1'b0);
    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
design/krg_pkg.sv
design/krg_div.sv
design/kiss_random_generator_unit.sv
tb/sv/testbench.sv
